@@ hw/rtl/kfi_pkg.sv @@
package kfi_pkg;

	// One keyframe as held by a cell of the table.
	typedef struct packed {
		logic        [31:0] tm;
		logic signed [15:0] yaw;
		logic signed [14:0] pitch;
		logic signed [15:0] roll;
		logic        [14:0] fov;
	} kfi_entry_t;

	// What a table cell does at the next clock edge.
	typedef enum logic [2:0] {
		CELL_HOLD,
		CELL_NEW,
		CELL_LEFT,
		CELL_RIGHT,
		CELL_ANGLES
	} kfi_cell_op_t;

	localparam logic [2:0] CMD_ADD    = 3'd0;
	localparam logic [2:0] CMD_REMOVE = 3'd1;
	localparam logic [2:0] CMD_UPDATE = 3'd2;
	localparam logic [2:0] CMD_EVAL   = 3'd3;
	localparam logic [2:0] CMD_READ   = 3'd4;

	localparam logic [1:0] ST_DONE      = 2'd0;
	localparam logic [1:0] ST_BAD_INDEX = 2'd1;
	localparam logic [1:0] ST_FULL      = 2'd2;
	localparam logic [1:0] ST_EMPTY     = 2'd3;

	// Angles in 1/128 degree.
	localparam int HALF_TURN = 23040;
	localparam int FULL_TURN = 46080;

	localparam int ALPHA_W = 17;
	localparam int LANE_W  = 18;

endpackage

@@ hw/rtl/kfi_cell.sv @@
module kfi_cell (
	input  logic                 clk,
	input  kfi_pkg::kfi_cell_op_t op,
	input  logic [31:0]          probe,
	input  kfi_pkg::kfi_entry_t  new_entry,
	input  kfi_pkg::kfi_entry_t  left_entry,
	input  kfi_pkg::kfi_entry_t  right_entry,
	output kfi_pkg::kfi_entry_t  entry,
	output logic                 lt,
	output logic                 eq
);
	import kfi_pkg::*;

	kfi_entry_t entry_q;

	always_ff @(posedge clk) begin
		case (op)
			CELL_NEW:    entry_q <= new_entry;
			CELL_LEFT:   entry_q <= left_entry;
			CELL_RIGHT:  entry_q <= right_entry;
			CELL_ANGLES: entry_q <= '{tm: entry_q.tm, yaw: new_entry.yaw,
				pitch: new_entry.pitch, roll: new_entry.roll, fov: new_entry.fov};
			default:     entry_q <= entry_q;
		endcase
	end

	// Each cell compares its own time against the probe time.
	assign entry = entry_q;
	assign lt    = entry_q.tm < probe;
	assign eq    = entry_q.tm == probe;

endmodule

@@ hw/rtl/kfi_div.sv @@
module kfi_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [31:0]                 num,
	input  logic [31:0]                 den,
	output logic                        busy,
	output logic [kfi_pkg::ALPHA_W-1:0] quo
);
	import kfi_pkg::*;

	// num never exceeds den, so the integer quotient bit is settled at start
	// and the sixteen fraction bits follow one per cycle. The integer bit
	// enters at the bottom and is shifted up to the top with them.
	logic [32:0]        rem_q;
	logic [31:0]        den_q;
	logic [ALPHA_W-1:0] quo_q;
	logic [4:0]         cnt_q;
	logic               busy_q;
	logic [33:0]        rem2;
	logic               fits;

	assign rem2 = {rem_q, 1'b0};
	assign fits = rem2 >= {2'b00, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= 5'd16;
		end else if (busy_q) begin
			cnt_q <= cnt_q - 5'd1;
			if (cnt_q == 5'd1) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			den_q <= den;
			if (num >= den) begin
				rem_q <= {1'b0, num - den};
				quo_q <= {{(ALPHA_W-1){1'b0}}, 1'b1};
			end else begin
				rem_q <= {1'b0, num};
				quo_q <= '0;
			end
		end else if (busy_q) begin
			if (fits) begin
				rem_q <= 33'(rem2 - {2'b00, den_q});
			end else begin
				rem_q <= rem2[32:0];
			end
			quo_q <= {quo_q[ALPHA_W-2:0], fits};
		end
	end

	assign busy = busy_q;
	assign quo  = quo_q;

endmodule

@@ hw/rtl/kfi_lerp.sv @@
module kfi_lerp (
	input  logic                               clk,
	input  logic                               load,
	input  logic                               wrap,
	input  logic signed [kfi_pkg::LANE_W-1:0]  a,
	input  logic signed [kfi_pkg::LANE_W-1:0]  b,
	input  logic        [kfi_pkg::ALPHA_W-1:0] alpha,
	output logic signed [kfi_pkg::LANE_W-1:0]  y
);
	import kfi_pkg::*;

	localparam int PROD_W = 2 * LANE_W;
	localparam int SUM_W  = PROD_W - 16 + 1;

	logic signed [LANE_W-1:0] d_raw;
	logic signed [LANE_W-1:0] d;
	logic signed [PROD_W-1:0] prod_s1;
	logic signed [LANE_W-1:0] a_s1;
	logic signed [SUM_W-1:0]  sum;
	logic signed [SUM_W-1:0]  sum_w;

	// Shortest path when wrap is set: a delta beyond a half turn goes the other way round.
	always_comb begin
		d_raw = b - a;
		d     = d_raw;
		if (wrap && d_raw > LANE_W'(HALF_TURN)) begin
			d = d_raw - LANE_W'(FULL_TURN);
		end else if (wrap && d_raw < -LANE_W'(HALF_TURN)) begin
			d = d_raw + LANE_W'(FULL_TURN);
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			prod_s1 <= PROD_W'(d) * PROD_W'($signed({1'b0, alpha}));
			a_s1    <= a;
		end
	end

	// The arithmetic shift floors the product of the delta and the Q1.16 alpha.
	always_comb begin
		sum   = SUM_W'(a_s1) + SUM_W'(prod_s1 >>> 16);
		sum_w = sum;
		if (wrap && sum > SUM_W'(HALF_TURN)) begin
			sum_w = sum - SUM_W'(FULL_TURN);
		end else if (wrap && sum < -SUM_W'(HALF_TURN)) begin
			sum_w = sum + SUM_W'(FULL_TURN);
		end
	end

	assign y = sum_w[LANE_W-1:0];

endmodule

@@ hw/rtl/keyframe_orientation_interpolator.sv @@
// Keyframe orientation interpolator. Holds up to MAX_KEYS camera keyframes
// sorted by time in a row of cells that shift toward either neighbor, so an
// insert or a removal moves the whole table in parallel. A command is taken
// when start is high and busy is low; its single result beat appears on the
// result ports for exactly one cycle with done high, and the receiver cannot
// hold it off. Add, remove, read, unknown commands and clamped or empty
// evaluations pass once through the execute state before done is registered.
// A valid update also passes through the insert state, because the entry is
// first taken out and then put back in time order. An evaluation inside the
// key range starts with the segment search, a parallel compare in the cells;
// a serial divider then works out the sixteen fraction bits of alpha while
// the sequencer waits in the divide state, and the four interpolation lanes
// multiply in the multiply state and sum in the sum state. The table starts
// empty after reset and needs no clearing pass.
module keyframe_orientation_interpolator #(
	parameter int MAX_KEYS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [2:0]         cmd,
	input  logic [3:0]         entry_index,
	input  logic [31:0]        key_time,
	input  logic signed [15:0] yaw_in,
	input  logic signed [14:0] pitch_in,
	input  logic signed [15:0] roll_in,
	input  logic [14:0]        fov_in,
	output logic               done,
	output logic [1:0]         status,
	output logic [31:0]        time_out,
	output logic signed [15:0] yaw_out,
	output logic signed [14:0] pitch_out,
	output logic signed [15:0] roll_out,
	output logic [14:0]        fov_out,
	output logic [4:0]         entry_count
);
	import kfi_pkg::*;

	localparam int CNT_W = $clog2(MAX_KEYS + 1);

	typedef enum logic [5:0] {
		S_IDLE = 6'b000001,
		S_EXEC = 6'b000010,
		S_INS  = 6'b000100,
		S_DIV  = 6'b001000,
		S_MUL  = 6'b010000,
		S_SUM  = 6'b100000
	} state_t;

	state_t state_q, state_d;

	// Command latched at start; the cells compare against op_time_q.
	logic [2:0]  op_cmd_q;
	logic [3:0]  op_idx_q;
	logic [31:0] op_time_q;
	kfi_entry_t  new_entry;
	kfi_entry_t  op_entry_q;

	logic [CNT_W-1:0] count_q;

	kfi_entry_t   ent    [MAX_KEYS];
	kfi_cell_op_t cell_op[MAX_KEYS];
	logic [MAX_KEYS-1:0] lt_w, eq_w, valid_w, ge_w, gt_w;
	logic [MAX_KEYS-1:0] first_eq, ins_pos, ins_shift, rm_shift;
	logic [MAX_KEYS-1:0] rd_sel, last_sel, seg_sel;

	logic any_eq, full, bad_idx, all_le;
	kfi_entry_t rd_e, last_e, seg_a, seg_b, key_e;
	kfi_entry_t seg_a_q, seg_b_q;

	logic        div_start, div_busy;
	logic [ALPHA_W-1:0] alpha;
	logic        lerp_load;
	logic signed [LANE_W-1:0] yaw_l, pitch_l, roll_l, fov_l;

	logic        emit;
	logic [1:0]  res_status_d;
	logic [31:0] res_time_d;
	kfi_entry_t  res_e_d;

	logic        done_q;
	logic [1:0]  res_status_q;
	logic [31:0] res_time_q;
	logic signed [15:0] res_yaw_q;
	logic signed [14:0] res_pitch_q;
	logic signed [15:0] res_roll_q;
	logic [14:0] res_fov_q;
	logic [4:0]  res_count_q;
	logic [CNT_W-1:0] count_d;

	assign new_entry = op_entry_q;

	// The table: each cell takes its left or right neighbor, the new entry,
	// or new angles for its own time.
	for (genvar k = 0; k < MAX_KEYS; k++) begin : g_cell
		kfi_cell u_cell (
			.clk        (clk),
			.op         (cell_op[k]),
			.probe      (op_time_q),
			.new_entry  (new_entry),
			.left_entry ((k == 0) ? new_entry : ent[(k == 0) ? 0 : k - 1]),
			.right_entry((k == MAX_KEYS - 1) ? ent[k] : ent[(k == MAX_KEYS - 1) ? k : k + 1]),
			.entry      (ent[k]),
			.lt         (lt_w[k]),
			.eq         (eq_w[k])
		);

		assign valid_w[k] = 32'(count_q) > k;
		assign ge_w[k]    = valid_w[k] && !lt_w[k];
		assign gt_w[k]    = valid_w[k] && !lt_w[k] && !eq_w[k];
		assign rd_sel[k]  = 32'(op_idx_q) == k;
		assign last_sel[k] = 32'(count_q) == k + 1;
		assign rm_shift[k] = k >= 32'(op_idx_q);

		// Equal times sit next to each other in a sorted table, so the
		// first match is the one whose left neighbor does not match.
		if (k == 0) begin : g_first
			assign first_eq[k]  = valid_w[k] && eq_w[k];
			assign ins_shift[k] = 1'b0;
			assign ins_pos[k]   = ge_w[k] || (count_q == '0);
			assign seg_sel[k]   = 1'b0;
		end else begin : g_rest
			assign first_eq[k]  = valid_w[k] && eq_w[k] && !(valid_w[k-1] && eq_w[k-1]);
			assign ins_shift[k] = ge_w[k-1];
			assign ins_pos[k]   = !ge_w[k-1] && (ge_w[k] || (32'(count_q) == k));
			assign seg_sel[k]   = ge_w[k] && !ge_w[k-1];
		end
	end

	assign any_eq  = |first_eq;
	assign full    = 32'(count_q) >= MAX_KEYS;
	assign bad_idx = 32'(op_idx_q) >= 32'(count_q);
	assign all_le  = ~|gt_w;

	// One-hot selections over the cells.
	always_comb begin
		rd_e   = '0;
		last_e = '0;
		seg_a  = '0;
		seg_b  = '0;
		for (int k = 0; k < MAX_KEYS; k++) begin
			rd_e   = rd_e | (ent[k] & {$bits(kfi_entry_t){rd_sel[k]}});
			last_e = last_e | (ent[k] & {$bits(kfi_entry_t){last_sel[k]}});
			seg_b  = seg_b | (ent[k] & {$bits(kfi_entry_t){seg_sel[k]}});
			if (k > 0) begin
				seg_a = seg_a | (ent[k-1] & {$bits(kfi_entry_t){seg_sel[k]}});
			end
		end
	end

	assign key_e = ge_w[0] ? ent[0] : last_e;

	kfi_div u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (div_start),
		.num   (op_time_q - seg_a.tm),
		.den   (seg_b.tm - seg_a.tm),
		.busy  (div_busy),
		.quo   (alpha)
	);

	assign lerp_load = state_q == S_MUL;

	kfi_lerp u_yaw (
		.clk(clk), .load(lerp_load), .wrap(1'b1),
		.a(LANE_W'(seg_a_q.yaw)), .b(LANE_W'(seg_b_q.yaw)), .alpha(alpha), .y(yaw_l)
	);
	kfi_lerp u_roll (
		.clk(clk), .load(lerp_load), .wrap(1'b1),
		.a(LANE_W'(seg_a_q.roll)), .b(LANE_W'(seg_b_q.roll)), .alpha(alpha), .y(roll_l)
	);
	kfi_lerp u_pitch (
		.clk(clk), .load(lerp_load), .wrap(1'b0),
		.a(LANE_W'(seg_a_q.pitch)), .b(LANE_W'(seg_b_q.pitch)), .alpha(alpha), .y(pitch_l)
	);
	kfi_lerp u_fov (
		.clk(clk), .load(lerp_load), .wrap(1'b0),
		.a($signed({3'b000, seg_a_q.fov})), .b($signed({3'b000, seg_b_q.fov})),
		.alpha(alpha), .y(fov_l)
	);

	// Sequencer: decides the cell operations and when a result beat goes out.
	always_comb begin
		state_d      = state_q;
		count_d      = count_q;
		div_start    = 1'b0;
		emit         = 1'b0;
		res_status_d = ST_DONE;
		res_time_d   = op_time_q;
		res_e_d      = '0;
		for (int k = 0; k < MAX_KEYS; k++) begin
			cell_op[k] = CELL_HOLD;
		end

		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					state_d = S_EXEC;
				end
			end
			S_EXEC: begin
				emit    = 1'b1;
				state_d = S_IDLE;
				case (op_cmd_q)
					CMD_ADD: begin
						if (any_eq) begin
							for (int k = 0; k < MAX_KEYS; k++) begin
								if (first_eq[k]) cell_op[k] = CELL_ANGLES;
							end
						end else if (full) begin
							res_status_d = ST_FULL;
						end else begin
							count_d = count_q + CNT_W'(1);
							for (int k = 0; k < MAX_KEYS; k++) begin
								if (ins_pos[k]) cell_op[k] = CELL_NEW;
								else if (ins_shift[k]) cell_op[k] = CELL_LEFT;
							end
						end
					end
					CMD_REMOVE, CMD_UPDATE: begin
						if (bad_idx) begin
							res_status_d = ST_BAD_INDEX;
						end else begin
							count_d = count_q - CNT_W'(1);
							for (int k = 0; k < MAX_KEYS; k++) begin
								if (rm_shift[k]) cell_op[k] = CELL_RIGHT;
							end
							if (op_cmd_q == CMD_UPDATE) begin
								emit    = 1'b0;
								state_d = S_INS;
							end
						end
					end
					CMD_READ: begin
						if (bad_idx) begin
							res_status_d = ST_BAD_INDEX;
						end else begin
							res_e_d    = rd_e;
							res_time_d = rd_e.tm;
						end
					end
					CMD_EVAL: begin
						if (count_q == '0) begin
							res_status_d = ST_EMPTY;
						end else if (ge_w[0] || all_le) begin
							res_e_d = key_e;
						end else begin
							emit      = 1'b0;
							div_start = 1'b1;
							state_d   = S_DIV;
						end
					end
					default: ;
				endcase
				res_e_d.tm = '0;
			end
			S_INS: begin
				emit    = 1'b1;
				state_d = S_IDLE;
				count_d = count_q + CNT_W'(1);
				for (int k = 0; k < MAX_KEYS; k++) begin
					if (ins_pos[k]) cell_op[k] = CELL_NEW;
					else if (ins_shift[k]) cell_op[k] = CELL_LEFT;
				end
			end
			S_DIV: begin
				if (!div_busy) begin
					state_d = S_MUL;
				end
			end
			S_MUL: begin
				state_d = S_SUM;
			end
			S_SUM: begin
				emit          = 1'b1;
				state_d       = S_IDLE;
				res_e_d.yaw   = yaw_l[15:0];
				res_e_d.pitch = pitch_l[14:0];
				res_e_d.roll  = roll_l[15:0];
				res_e_d.fov   = fov_l[14:0];
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			done_q  <= emit;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && start) begin
			op_cmd_q   <= cmd;
			op_idx_q   <= entry_index;
			op_time_q  <= key_time;
			op_entry_q <= '{tm: key_time, yaw: yaw_in, pitch: pitch_in,
				roll: roll_in, fov: fov_in};
		end
		if (div_start) begin
			seg_a_q <= seg_a;
			seg_b_q <= seg_b;
		end
		if (emit) begin
			res_status_q <= res_status_d;
			res_time_q   <= res_time_d;
			res_yaw_q    <= res_e_d.yaw;
			res_pitch_q  <= res_e_d.pitch;
			res_roll_q   <= res_e_d.roll;
			res_fov_q    <= res_e_d.fov;
			res_count_q  <= 5'(count_d);
		end
	end

	assign busy        = state_q != S_IDLE;
	assign done        = done_q;
	assign status      = res_status_q;
	assign time_out    = res_time_q;
	assign yaw_out     = res_yaw_q;
	assign pitch_out   = res_pitch_q;
	assign roll_out    = res_roll_q;
	assign fov_out     = res_fov_q;
	assign entry_count = res_count_q;

endmodule
